FILE: design/jlmp_pkg.sv
package jlmp_pkg;

    // Field widths fixed by the interface.
    localparam int FRAC_BITS_DEF = 16;
    localparam int POS_W         = 48;
    localparam int VAL_W         = 32;
    localparam int UVAL_W        = 31;
    localparam int DT_W          = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // Shared multiplier and accumulation widths.
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = PROD_W + 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TACC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VMAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AMAX     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_JLIM     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DT       = 3'd7;

    // Configuration reset values.
    localparam logic [UVAL_W-1:0] VMAX_RST = 31'd6553600;
    localparam logic [VAL_W-1:0]  AMIN_RST = 32'hFFFF_0000;
    localparam logic [UVAL_W-1:0] AMAX_RST = 31'd65536;
    localparam logic [UVAL_W-1:0] JLIM_RST = 31'd65536;
    localparam logic [DT_W-1:0]   DT_RST   = 16'd655;

    // Datapath step codes.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_DT2   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_UA2   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_VJ    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ATGT  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_THR   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SNAP  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_PV    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_PA    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_PJ    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_VA    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_VJ2   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_ACC   = 4'd11;
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_ACC;

    typedef struct packed {
        logic                     mode;
        logic [UVAL_W-1:0]        tvel;
        logic signed [VAL_W-1:0]  tacc;
        logic [UVAL_W-1:0]        vmax;
        logic signed [VAL_W-1:0]  amin;
        logic [UVAL_W-1:0]        amax;
        logic [UVAL_W-1:0]        jlim;
        logic [DT_W-1:0]          dt;
    } cfg_t;

    typedef struct packed {
        logic              do_load;
        logic              step_en;
        logic [STEP_W-1:0] step;
        logic              pos_update;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } sts_t;

    // Lower bound first, then upper bound, so the upper bound wins when crossed.
    function automatic logic signed [SUM_W-1:0] clamp_s(
        input logic signed [SUM_W-1:0] x,
        input logic signed [SUM_W-1:0] lo,
        input logic signed [SUM_W-1:0] hi
    );
        logic signed [SUM_W-1:0] y;
        y = x;
        if (y < lo) y = lo;
        if (y > hi) y = hi;
        return y;
    endfunction

endpackage

FILE: design/jlmp_div6.sv
module jlmp_div6 import jlmp_pkg::*; #(
    parameter int W = PROD_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] dividend,
    output logic signed [W-1:0] quot,
    output logic                done
);

    // Floor division by six through a reciprocal multiply. The dividend is the
    // scaled cubic jerk term, whose magnitude always stays below 2^31, so a
    // 32 bit magnitude is enough.
    localparam int NW  = 32;
    localparam int RSH = NW + 2;
    localparam logic [NW-1:0] RECIP6 = 32'hAAAA_AAAB;

    logic [NW-1:0]   n_reg;
    logic [W-1:0]    q_reg;
    logic            neg_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [NW-1:0]   n_start;
    logic [2*NW-1:0] prod;

    // A negative x gives floor(x/6) = ~((~x)/6).
    assign n_start = dividend[W-1] ? ~dividend[NW-1:0] : dividend[NW-1:0];
    assign prod    = n_reg * RECIP6;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[W-1];
            n_reg   <= n_start;
        end else if (busy_reg) begin
            q_reg <= W'(prod[2*NW-1:RSH]);
        end
    end

    assign quot = neg_reg ? $signed(~q_reg) : $signed(q_reg);
    assign done = done_reg;

endmodule

FILE: design/jlmp_ctrl.sv
module jlmp_ctrl import jlmp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_op,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op) begin
                        cmd.do_load = 1'b1;
                        state_next  = ST_DONE;
                    end else begin
                        step_next  = STEP_DT2;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                cmd.step_en = 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_DIV;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.pos_update = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_DT2;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: design/jlmp_dpath.sv
module jlmp_dpath import jlmp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic signed [POS_W-1:0]  s_load_position,
    input  logic signed [VAL_W-1:0]  s_load_velocity,
    input  logic signed [VAL_W-1:0]  s_load_acceleration,
    output logic signed [POS_W-1:0]  m_position_out,
    output logic signed [VAL_W-1:0]  m_velocity_out,
    output logic signed [VAL_W-1:0]  m_acceleration_out,
    output logic signed [VAL_W-1:0]  m_jerk_out
);

    localparam int VERR_W = VAL_W + 2;

    logic signed [POS_W-1:0]  pos_reg;
    logic signed [VAL_W-1:0]  vel_reg, acc_reg, jrk_reg;
    logic signed [PROD_W-1:0] prod_reg, sq_reg;
    logic [VAL_W-1:0]         dt2_reg, dt3_reg;
    logic signed [VERR_W-1:0] verr_reg;
    logic signed [VAL_W-1:0]  atgt_reg;
    logic signed [SUM_W-1:0]  dp_reg, dv_reg;
    logic signed [POS_W-1:0]  out_pos_reg;
    logic signed [VAL_W-1:0]  out_vel_reg, out_acc_reg, out_jrk_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] p_sh, p_sh1, div_q;
    logic [UVAL_W-1:0]        jl;
    logic signed [VAL_W-1:0]  jl_s;
    logic signed [SUM_W-1:0]  vmax_x, amin_x, amax_x, tv_x, verr_x, atgt1_x;
    logic signed [SUM_W-1:0]  acc_x, ua_x, verr_abs_x, aerr_x, aerr_abs_x;
    logic signed [SUM_W-1:0]  acc_n, vel_n, pos_n;
    logic                     div_start, div_done;

    assign jl     = (cfg.jlim == '0) ? UVAL_W'(1) : cfg.jlim;
    assign jl_s   = $signed({1'b0, jl});
    assign vmax_x = $signed(SUM_W'(cfg.vmax));
    assign amax_x = $signed(SUM_W'(cfg.amax));
    assign amin_x = SUM_W'($signed(cfg.amin));
    assign acc_x  = SUM_W'(acc_reg);

    assign tv_x       = clamp_s($signed(SUM_W'(cfg.tvel)), '0, vmax_x);
    assign verr_x     = tv_x - SUM_W'(vel_reg);
    assign atgt1_x    = clamp_s(SUM_W'($signed(cfg.tacc)), amin_x, amax_x);
    assign ua_x       = (acc_x < 0) ? -acc_x : acc_x;
    assign verr_abs_x = (verr_reg < 0) ? -SUM_W'(verr_reg) : SUM_W'(verr_reg);
    assign aerr_x     = SUM_W'(atgt_reg) - acc_x;
    assign aerr_abs_x = (aerr_x < 0) ? -aerr_x : aerr_x;

    assign p_sh  = prod_reg >>> FRAC_BITS;
    assign p_sh1 = prod_reg >>> (FRAC_BITS + 1);

    assign acc_n = clamp_s(acc_x + SUM_W'(p_sh), amin_x, amax_x);
    assign vel_n = clamp_s(SUM_W'(vel_reg) + dv_reg, '0, vmax_x);
    assign pos_n = clamp_s(SUM_W'(pos_reg) + dp_reg + SUM_W'(div_q),
                           -(SUM_W'(1) <<< (POS_W - 1)),
                           (SUM_W'(1) <<< (POS_W - 1)) - SUM_W'(1));

    // Operand select for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            STEP_DT2:  begin mul_a = $signed(MUL_W'(cfg.dt));    mul_b = $signed(MUL_W'(cfg.dt)); end
            STEP_UA2:  begin mul_a = ua_x[MUL_W-1:0];            mul_b = ua_x[MUL_W-1:0]; end
            STEP_VJ:   begin mul_a = verr_abs_x[MUL_W-1:0];      mul_b = $signed(MUL_W'({jl, 1'b0})); end
            STEP_ATGT: begin mul_a = $signed(MUL_W'(dt2_reg));   mul_b = $signed(MUL_W'(cfg.dt)); end
            STEP_THR:  begin mul_a = $signed(MUL_W'(jl));        mul_b = $signed(MUL_W'(cfg.dt)); end
            STEP_SNAP: begin mul_a = MUL_W'(vel_reg);            mul_b = $signed(MUL_W'(cfg.dt)); end
            STEP_PV:   begin mul_a = MUL_W'(acc_reg);            mul_b = $signed(MUL_W'(dt2_reg)); end
            STEP_PA:   begin mul_a = MUL_W'(jrk_reg);            mul_b = $signed(MUL_W'(dt3_reg)); end
            STEP_PJ:   begin mul_a = MUL_W'(acc_reg);            mul_b = $signed(MUL_W'(cfg.dt)); end
            STEP_VA:   begin mul_a = MUL_W'(jrk_reg);            mul_b = $signed(MUL_W'(dt2_reg)); end
            STEP_VJ2:  begin mul_a = MUL_W'(jrk_reg);            mul_b = $signed(MUL_W'(cfg.dt)); end
            default:   begin mul_a = '0;                         mul_b = '0; end
        endcase
    end

    assign div_start = cmd.step_en && (cmd.step == STEP_PJ);

    jlmp_div6 #(
        .W(PROD_W)
    ) u_div6 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (p_sh),
        .quot     (div_q),
        .done     (div_done)
    );

    assign sts.div_done = div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            vel_reg <= '0;
            acc_reg <= '0;
            jrk_reg <= '0;
        end else if (cmd.do_load) begin
            pos_reg <= s_load_position;
            vel_reg <= s_load_velocity;
            acc_reg <= s_load_acceleration;
            jrk_reg <= '0;
        end else if (cmd.pos_update) begin
            pos_reg <= pos_n[POS_W-1:0];
        end else if (cmd.step_en) begin
            case (cmd.step)
                STEP_SNAP: begin
                    if (aerr_abs_x < SUM_W'(p_sh)) begin
                        acc_reg <= atgt_reg;
                        jrk_reg <= '0;
                    end else begin
                        jrk_reg <= (aerr_x > 0) ? jl_s : -jl_s;
                    end
                end
                STEP_ACC: begin
                    vel_reg <= vel_n[VAL_W-1:0];
                    if (cfg.mode && (vel_n >= vmax_x) && (acc_n > 0)) begin
                        acc_reg <= '0;
                        jrk_reg <= '0;
                    end else begin
                        acc_reg <= acc_n[VAL_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.step_en) begin
            case (cmd.step)
                STEP_DT2:  verr_reg <= verr_x[VERR_W-1:0];
                STEP_UA2:  dt2_reg  <= p_sh[VAL_W-1:0];
                STEP_VJ:   sq_reg   <= prod_reg;
                STEP_ATGT: begin
                    if (cfg.mode) begin
                        atgt_reg <= atgt1_x[VAL_W-1:0];
                    end else if (prod_reg > sq_reg) begin
                        atgt_reg <= (verr_reg > 0) ? amax_x[VAL_W-1:0] : amin_x[VAL_W-1:0];
                    end else begin
                        atgt_reg <= '0;
                    end
                end
                STEP_THR:  dt3_reg <= p_sh[VAL_W-1:0];
                STEP_PV:   dp_reg  <= SUM_W'(p_sh);
                STEP_PA:   dp_reg  <= dp_reg + SUM_W'(p_sh1);
                STEP_VA:   dv_reg  <= SUM_W'(p_sh);
                STEP_VJ2:  dv_reg  <= dv_reg + SUM_W'(p_sh1);
                default: begin
                end
            endcase
        end
        if (cmd.out_load) begin
            out_pos_reg <= pos_reg;
            out_vel_reg <= vel_reg;
            out_acc_reg <= acc_reg;
            out_jrk_reg <= jrk_reg;
        end
    end

    assign m_position_out     = out_pos_reg;
    assign m_velocity_out     = out_vel_reg;
    assign m_acceleration_out = out_acc_reg;
    assign m_jerk_out         = out_jrk_reg;

endmodule

FILE: design/jerk_limited_motion_profiler_core.sv
// Jerk-limited S-curve motion profiler. Each advance item (s_op low) moves the
// position, velocity, acceleration and jerk state forward by one time step and
// returns the new state; a load item (s_op high) writes position, velocity and
// acceleration directly, clears jerk, and returns that state. Velocity and
// acceleration are Q16.16 with FRAC_BITS fraction bits, position is Q32.16 and
// saturates. A load item's state is registered on acceptance and copied to the
// output register once that register is free; the next item is accepted after
// that. An advance runs twelve steps through one shared 34 by 34 bit
// multiplier, then a separate state adds the cubic jerk term to the position;
// the floor division by six of that term is a reciprocal multiply that
// finishes while the last steps still run. The result is then copied to the
// output register once it is free, and the next item is accepted after that.
// One item is worked on at a time, but a new item is accepted while the
// previous result still waits in the output register. The user must write the
// configuration registers through the cfg port only while the block is idle;
// the block itself does not enforce this. cfg_ready is always high.
module jerk_limited_motion_profiler_core import jlmp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic signed [POS_W-1:0]     s_load_position,
    input  logic signed [VAL_W-1:0]     s_load_velocity,
    input  logic signed [VAL_W-1:0]     s_load_acceleration,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [POS_W-1:0]     m_position_out,
    output logic signed [VAL_W-1:0]     m_velocity_out,
    output logic signed [VAL_W-1:0]     m_acceleration_out,
    output logic signed [VAL_W-1:0]     m_jerk_out,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    // Each register keeps only the bits of its own width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode <= 1'b0;
            cfg_reg.tvel <= '0;
            cfg_reg.tacc <= '0;
            cfg_reg.vmax <= VMAX_RST;
            cfg_reg.amin <= AMIN_RST;
            cfg_reg.amax <= AMAX_RST;
            cfg_reg.jlim <= JLIM_RST;
            cfg_reg.dt   <= DT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MODE: cfg_reg.mode <= cfg_data[0];
                REG_TVEL: cfg_reg.tvel <= cfg_data[UVAL_W-1:0];
                REG_TACC: cfg_reg.tacc <= cfg_data;
                REG_VMAX: cfg_reg.vmax <= cfg_data[UVAL_W-1:0];
                REG_AMIN: cfg_reg.amin <= cfg_data;
                REG_AMAX: cfg_reg.amax <= cfg_data[UVAL_W-1:0];
                REG_JLIM: cfg_reg.jlim <= cfg_data[UVAL_W-1:0];
                REG_DT:   cfg_reg.dt   <= cfg_data[DT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The controller sequences the steps; the datapath holds the state.
    jlmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    jlmp_dpath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dpath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .cmd                 (cmd),
        .sts                 (sts),
        .s_load_position     (s_load_position),
        .s_load_velocity     (s_load_velocity),
        .s_load_acceleration (s_load_acceleration),
        .m_position_out      (m_position_out),
        .m_velocity_out      (m_velocity_out),
        .m_acceleration_out  (m_acceleration_out),
        .m_jerk_out          (m_jerk_out)
    );

endmodule

FILE: bench/jerk_limited_motion_profiler_core_test.sv
`timescale 1ns / 1ps

module jerk_limited_motion_profiler_core_test;
    import jlmp_pkg::*;

    // Input item codes.
    localparam bit OP_ADVANCE = 1'b0;
    localparam bit OP_LOAD    = 1'b1;

    localparam longint POS_TOP = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint POS_BOT = -POS_TOP - 1;

    typedef struct {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] vel;
        logic [VAL_W-1:0] acc;
        logic [VAL_W-1:0] jrk;
    } kin_state_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_op;
    logic signed [POS_W-1:0] s_load_position;
    logic signed [VAL_W-1:0] s_load_velocity;
    logic signed [VAL_W-1:0] s_load_acceleration;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [POS_W-1:0] m_position_out;
    logic signed [VAL_W-1:0] m_velocity_out;
    logic signed [VAL_W-1:0] m_acceleration_out;
    logic signed [VAL_W-1:0] m_jerk_out;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    jerk_limited_motion_profiler_core dut (.*);

    // Shadow copy of the configuration registers, updated when a write is accepted.
    logic                    sh_mode;
    logic [UVAL_W-1:0]       sh_tvel;
    logic signed [VAL_W-1:0] sh_tacc;
    logic [UVAL_W-1:0]       sh_vmax;
    logic signed [VAL_W-1:0] sh_amin;
    logic [UVAL_W-1:0]       sh_amax;
    logic [UVAL_W-1:0]       sh_jlim;
    logic [DT_W-1:0]         sh_dt;

    // Predicted kinematic state, kept at full precision.
    longint kin_pos, kin_vel, kin_acc, kin_jrk;

    kin_state_t expected_states[$];

    int  errors;
    int  results_seen;
    int  loads_sent;
    int  advances_sent;
    bit  no_idle;
    int  long_hold;
    int  stall_left;

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Round toward minus infinity, as the block's integrators do.
    function automatic longint floor_div(input longint x, input longint d);
        longint q;
        q = x / d;
        if ((x % d) != 0 && x < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint clamp_range(input longint x, input longint lo, input longint hi);
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        return x;
    endfunction

    function automatic longint mag(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Advance the shadow kinematic state by one time step.
    task automatic integrate_step();
        longint vmax, amin, amax, jl, dt, one, dt2, dt3;
        longint tv, verr, atgt, aerr, thr, dp, dv;
        longint unsigned ua, stop_dist;
        vmax = longint'(sh_vmax);
        amin = longint'(sh_amin);
        amax = longint'(sh_amax);
        jl   = (sh_jlim == 0) ? 1 : longint'(sh_jlim);
        dt   = longint'(sh_dt);
        one  = longint'(1) << FRAC_BITS_DEF;
        dt2  = (dt * dt) >>> FRAC_BITS_DEF;
        dt3  = (dt2 * dt) >>> FRAC_BITS_DEF;
        if (sh_mode == 1'b0) begin
            // Velocity mode: brake to zero acceleration once the remaining
            // velocity error fits inside the jerk-limited ramp-down.
            tv = clamp_range(longint'(sh_tvel), 0, vmax);
            verr = tv - kin_vel;
            ua = longint'(mag(kin_acc));
            stop_dist = (ua * ua) / longint'(jl * 2);
            if (longint'(mag(verr)) > stop_dist) atgt = (verr > 0) ? amax : amin;
            else atgt = 0;
        end else begin
            atgt = clamp_range(longint'(sh_tacc), amin, amax);
        end
        aerr = atgt - kin_acc;
        thr = (jl * dt) >>> FRAC_BITS_DEF;
        if (mag(aerr) < thr) begin
            kin_acc = atgt;
            kin_jrk = 0;
        end else begin
            kin_jrk = (aerr > 0) ? jl : -jl;
        end
        dp = floor_div(kin_vel * dt, one) + floor_div(kin_acc * dt2, one * 2)
           + floor_div(kin_jrk * dt3, one * 6);
        dv = floor_div(kin_acc * dt, one) + floor_div(kin_jrk * dt2, one * 2);
        kin_pos = clamp_range(kin_pos + dp, POS_BOT, POS_TOP);
        kin_vel = kin_vel + dv;
        kin_acc = kin_acc + floor_div(kin_jrk * dt, one);
        kin_acc = clamp_range(kin_acc, amin, amax);
        kin_vel = clamp_range(kin_vel, 0, vmax);
        // Acceleration mode stops pushing once top speed is reached.
        if (sh_mode != 1'b0 && kin_vel >= vmax && kin_acc > 0) begin
            kin_acc = 0;
            kin_jrk = 0;
        end
    endtask

    // Offer one item, hold it until accepted, then record the expected state.
    task automatic send_item(input bit op, input logic [POS_W-1:0] lp,
                             input logic [VAL_W-1:0] lv, input logic [VAL_W-1:0] la);
        int gap;
        kin_state_t k;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_op                <= op;
        s_load_position     <= lp;
        s_load_velocity     <= lv;
        s_load_acceleration <= la;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_LOAD) begin
            kin_pos = longint'($signed(lp));
            kin_vel = longint'($signed(lv));
            kin_acc = longint'($signed(la));
            kin_jrk = 0;
            loads_sent++;
        end else begin
            integrate_step();
            advances_sent++;
        end
        k.pos = kin_pos[POS_W-1:0];
        k.vel = kin_vel[VAL_W-1:0];
        k.acc = kin_acc[VAL_W-1:0];
        k.jrk = kin_jrk[VAL_W-1:0];
        expected_states.push_back(k);
    endtask

    task automatic advance_n(input int n);
        repeat (n) send_item(OP_ADVANCE, $urandom, $urandom, $urandom);
    endtask

    // Lower valid and wait until every predicted state has come back.
    task automatic wait_drain();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (expected_states.size() != 0) begin
            @(posedge aclk);
            waited++;
            if (waited > 50000) begin
                $display("%0t: timeout with %0d states outstanding", $realtime,
                         expected_states.size());
                $display("jerk_limited_motion_profiler_core_test: errors");
                $finish;
            end
        end
    endtask

    // Write one register; the block must be idle, so drain first.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODE: sh_mode = val[0];
            REG_TVEL: sh_tvel = val[UVAL_W-1:0];
            REG_TACC: sh_tacc = val;
            REG_VMAX: sh_vmax = val[UVAL_W-1:0];
            REG_AMIN: sh_amin = val;
            REG_AMAX: sh_amax = val[UVAL_W-1:0];
            REG_JLIM: sh_jlim = val[UVAL_W-1:0];
            REG_DT:   sh_dt   = val[DT_W-1:0];
            default: ;
        endcase
    endtask

    // Receiver: random stalls per result, plus an optional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_hold > 0) begin
            m_ready <= 1'b0;
            long_hold = long_hold - 1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (m_valid && m_ready) begin
            stall_left = no_idle ? 0 : $urandom_range(0, 4);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left = stall_left - 1;
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Each accepted result is compared with the oldest prediction.
    always @(posedge aclk) begin
        kin_state_t k;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_states.size() == 0) begin
                $display("%0t: unexpected result pos %h vel %h acc %h jerk %h", $realtime,
                         m_position_out, m_velocity_out, m_acceleration_out, m_jerk_out);
                errors++;
            end else begin
                k = expected_states.pop_front();
                if (m_position_out !== k.pos) begin
                    $display("%0t: position expected %h actual %h", $realtime, k.pos,
                             m_position_out);
                    errors++;
                end
                if (m_velocity_out !== k.vel) begin
                    $display("%0t: velocity expected %h actual %h", $realtime, k.vel,
                             m_velocity_out);
                    errors++;
                end
                if (m_acceleration_out !== k.acc) begin
                    $display("%0t: acceleration expected %h actual %h", $realtime, k.acc,
                             m_acceleration_out);
                    errors++;
                end
                if (m_jerk_out !== k.jrk) begin
                    $display("%0t: jerk expected %h actual %h", $realtime, k.jrk, m_jerk_out);
                    errors++;
                end
            end
        end
    end

    // Reset defaults first, then the saturating and clamping corners.
    task automatic test_directed();
        send_item(OP_ADVANCE, 0, 0, 0);
        send_item(OP_LOAD, 0, 32'd65536, 0);
        advance_n(2);
        // Position saturates upward from the top of its range.
        send_item(OP_LOAD, 48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        advance_n(1);
        // Negative velocity drives position into the bottom rail.
        send_item(OP_LOAD, 48'h8000_0000_0000, 32'h8000_0000, 32'h8000_0000);
        advance_n(1);
        write_reg(REG_DT, 16'hFFFF);
        write_reg(REG_JLIM, 32'h7FFF_FFFF);
        write_reg(REG_TVEL, 32'h7FFF_FFFF);
        write_reg(REG_VMAX, 32'h7FFF_FFFF);
        send_item(OP_LOAD, 0, 0, 0);
        advance_n(2);
        // Zero time step: jerk is chosen but nothing integrates.
        write_reg(REG_DT, 0);
        advance_n(1);
        // Zero jerk limit behaves as the smallest positive limit.
        write_reg(REG_DT, 16'd1);
        write_reg(REG_JLIM, 0);
        advance_n(1);
        // Crossed acceleration limits: the upper bound wins.
        write_reg(REG_AMIN, 32'd1000);
        write_reg(REG_AMAX, 32'd10);
        write_reg(REG_DT, 16'd655);
        write_reg(REG_JLIM, 32'd65536);
        advance_n(2);
        // Acceleration mode at top speed drops acceleration and jerk.
        write_reg(REG_AMIN, 32'h8000_0000);
        write_reg(REG_AMAX, 32'h7FFF_FFFF);
        write_reg(REG_VMAX, 32'd655360);
        write_reg(REG_TACC, 32'd65536);
        write_reg(REG_MODE, 1'b1);
        send_item(OP_LOAD, 48'd12345, 32'd655360, 32'd70000);
        advance_n(2);
        write_reg(REG_TACC, 32'h8000_0000);
        advance_n(1);
        wait_drain();
    endtask

    // Pick a register setting: mostly a plausible profile, sometimes a corner.
    task automatic random_config();
        logic [31:0] v;
        write_reg(REG_MODE, $urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 32'h7FFF_FFFF;
            default: v = $urandom_range(1 << 16, 1 << 26);
        endcase
        write_reg(REG_VMAX, v);
        write_reg(REG_TVEL, ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, v + 1000));
        case ($urandom_range(0, 7))
            0: v = 32'h8000_0000;
            1: v = 0;
            2: v = $urandom_range(0, 1 << 18);
            default: v = -$urandom_range(1 << 12, 1 << 20);
        endcase
        write_reg(REG_AMIN, v);
        case ($urandom_range(0, 7))
            0: v = 32'h7FFF_FFFF;
            1: v = 0;
            default: v = $urandom_range(1 << 12, 1 << 20);
        endcase
        write_reg(REG_AMAX, v);
        write_reg(REG_TACC, ($urandom_range(0, 3) == 0) ? $urandom
                            : $urandom_range(0, 1 << 21) - (1 << 20));
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 32'h7FFF_FFFF;
            2: v = 1;
            default: v = $urandom_range(1 << 14, 1 << 22);
        endcase
        write_reg(REG_JLIM, v);
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 16'hFFFF;
            2: v = 1;
            default: v = $urandom_range(100, 4000);
        endcase
        write_reg(REG_DT, v);
    endtask

    // Each phase: a setting, a sensible start state, then a run of advances
    // with an occasional load of arbitrary bits mixed in.
    task automatic test_random_profiles(input int phases, input int steps);
        for (int p = 0; p < phases; p++) begin
            no_idle = ($urandom_range(0, 4) == 0);
            random_config();
            send_item(OP_LOAD, {$urandom, $urandom} >> ($urandom_range(16, 40)),
                      $urandom_range(0, 1 << 24), $urandom_range(0, 1 << 17) - (1 << 16));
            for (int i = 0; i < steps; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_LOAD, {$urandom, $urandom}, $urandom, $urandom);
                else
                    advance_n(1);
            end
        end
        no_idle = 1'b0;
        wait_drain();
    endtask

    // Hold the receiver off long enough that the block stalls its input.
    task automatic test_backpressure();
        no_idle = 1'b1;
        long_hold = 300;
        advance_n(20);
        wait_drain();
        no_idle = 1'b0;
    endtask

    // The sender stops until everything has come back, then resumes.
    task automatic test_sender_pause();
        advance_n(10);
        wait_drain();
        advance_n(10);
        wait_drain();
    endtask

    initial begin
        aresetn             = 1'b0;
        s_valid             = 1'b0;
        s_op                = OP_ADVANCE;
        s_load_position     = '0;
        s_load_velocity     = '0;
        s_load_acceleration = '0;
        m_ready             = 1'b0;
        cfg_valid           = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        errors = 0;
        results_seen = 0;
        loads_sent = 0;
        advances_sent = 0;
        no_idle = 1'b0;
        long_hold = 0;
        stall_left = 0;
        sh_mode = 1'b0;
        sh_tvel = '0;
        sh_tacc = '0;
        sh_vmax = VMAX_RST;
        sh_amin = AMIN_RST;
        sh_amax = AMAX_RST;
        sh_jlim = JLIM_RST;
        sh_dt   = DT_RST;
        kin_pos = 0;
        kin_vel = 0;
        kin_acc = 0;
        kin_jrk = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_sender_pause();
        test_random_profiles(24, 62);

        wait_drain();
        repeat (60) @(posedge aclk);
        $display("Covered %0d loads and %0d advances over random profiles, corners,",
                 loads_sent, advances_sent);
        $display("back-pressure and sender pauses; %0d results checked.", results_seen);
        if (errors == 0 && expected_states.size() == 0) begin
            $display("jerk_limited_motion_profiler_core_test: clean");
        end else begin
            $display("jerk_limited_motion_profiler_core_test: errors");
        end
        $finish;
    end

    // Overall limit, far beyond the slowest correct run.
    initial begin
        #8ms;
        $display("jerk_limited_motion_profiler_core_test: errors");
        $finish;
    end

endmodule
